FILE: rtl/mbup_pkg.sv
// shared types and constants for the midi byte to usb event parser
`timescale 1ns / 1ps

package mbup_pkg;

    localparam int SYSEX_MAX_DEF = 46;
    localparam int COUNT_W       = 6;

    localparam logic [3:0] CABLE_RESET = 4'd1;

    // usb-midi code index numbers
    localparam logic [3:0] CIN_SYS2     = 4'h2;
    localparam logic [3:0] CIN_SYS3     = 4'h3;
    localparam logic [3:0] CIN_SYS1     = 4'h5;
    localparam logic [3:0] CIN_SYSEX    = 4'h7;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [3:0] CIN_RT       = 4'hF;

    // status bytes
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_MTC       = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] ST_TUNE      = 8'hF6;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_CLOCK     = 8'hF8;
    localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
    localparam logic [7:0] ST_START     = 8'hFA;
    localparam logic [7:0] ST_CONTINUE  = 8'hFB;
    localparam logic [7:0] ST_STOP      = 8'hFC;
    localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;
    localparam logic [7:0] ST_ACT_SENSE = 8'hFE;
    localparam logic [7:0] ST_RESET     = 8'hFF;

    // channel message high nibbles
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_POLY_AT  = 4'hA;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
    localparam logic [3:0] NIB_BEND     = 4'hE;

    localparam logic [7:0] NOTE_ON_OFF_BIT = 8'h10;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        line_error;
        logic        overrun;
        logic [31:0] arrival_time;
    } t_in_word;

    typedef struct packed {
        logic               event_valid;
        logic [7:0]         packet_header;
        logic [7:0]         midi_byte0;
        logic [7:0]         midi_byte1;
        logic [7:0]         midi_byte2;
        logic [31:0]        event_time;
        logic               sysex_write;
        logic [COUNT_W-1:0] sysex_index;
        logic [6:0]         sysex_data;
    } t_out_word;

    typedef struct packed {
        logic [7:0]         running_status;
        logic [3:0]         code_index;
        logic [6:0]         first_data;
        logic [1:0]         expected_bytes;
        logic [COUNT_W-1:0] collected_count;
        logic [31:0]        last_time;
    } t_state;

endpackage

FILE: rtl/mbup_parse.sv
// parser state registers and the per-byte decode logic
`timescale 1ns / 1ps

module mbup_parse #(
    parameter int SYSEX_MAX = mbup_pkg::SYSEX_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_step,
    input  mbup_pkg::t_in_word  i_word,
    output mbup_pkg::t_out_word o_result
);
    import mbup_pkg::*;

    t_state     r_st;
    t_state     n_st;
    logic [3:0] r_cable;
    t_out_word  w_res;

    logic [7:0]         w_b;
    logic [COUNT_W-1:0] w_cnt_inc;
    logic [7:0]         w_sb;
    logic [3:0]         w_cin;

    function automatic t_state f_clear(input t_state s);
        t_state c;
        c = s;
        c.running_status  = '0;
        c.code_index      = '0;
        c.expected_bytes  = '0;
        c.collected_count = '0;
        return c;
    endfunction

    function automatic t_state f_arm(input t_state s, input logic [3:0] cin,
                                     input logic [7:0] status, input logic [1:0] need);
        t_state c;
        c = s;
        c.code_index      = cin;
        c.running_status  = status;
        c.expected_bytes  = need;
        c.collected_count = '0;
        return c;
    endfunction

    function automatic t_out_word f_emit(input logic [3:0] cable, input logic [3:0] cin,
                                         input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [31:0] tm);
        t_out_word w;
        w = '0;
        w.event_valid   = 1'b1;
        w.packet_header = {cable, cin};
        w.midi_byte0    = b0;
        w.midi_byte1    = b1;
        w.midi_byte2    = b2;
        w.event_time    = tm;
        return w;
    endfunction

    assign w_b       = i_word.rx_byte;
    assign w_cnt_inc = r_st.collected_count + COUNT_W'(1);

    always_comb begin
        n_st  = r_st;
        w_res = '0;
        w_sb  = r_st.running_status;
        w_cin = r_st.code_index;
        if (i_word.line_error) begin
            n_st = f_clear(r_st);
        end else begin
            n_st.last_time = i_word.arrival_time;
            if (w_b[7]) begin
                unique case (w_b)
                    ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP: begin
                        w_res = f_emit(r_cable, CIN_RT, w_b, 8'd0, 8'd0, i_word.arrival_time);
                    end
                    ST_RESET: begin
                        w_res = f_emit(r_cable, CIN_RT, w_b, 8'd0, 8'd0, i_word.arrival_time);
                        n_st  = f_clear(n_st);
                    end
                    ST_ACT_SENSE, ST_UNDEF_F9, ST_UNDEF_FD: begin
                    end
                    ST_SYSEX:    n_st = f_arm(n_st, CIN_SYSEX, ST_SYSEX, 2'd2);
                    ST_SONG_POS: n_st = f_arm(n_st, CIN_SYS3, w_b, 2'd2);
                    ST_MTC, ST_SONG_SEL: n_st = f_arm(n_st, CIN_SYS2, w_b, 2'd1);
                    ST_UNDEF_F4, ST_UNDEF_F5: n_st = f_clear(n_st);
                    ST_TUNE: begin
                        w_res = f_emit(r_cable, CIN_SYS1, w_b, 8'd0, 8'd0, i_word.arrival_time);
                        n_st  = f_clear(n_st);
                    end
                    ST_EOX: begin
                        if (r_st.running_status == ST_SYSEX && r_st.collected_count != '0) begin
                            w_res = f_emit(r_cable, CIN_SYSEX, ST_SYSEX,
                                           8'(r_st.collected_count), ST_EOX,
                                           i_word.arrival_time);
                        end
                        n_st = f_clear(n_st);
                    end
                    default: begin
                        unique case (w_b[7:4])
                            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND:
                                n_st = f_arm(n_st, w_b[7:4], w_b, 2'd2);
                            NIB_PROG, NIB_CHAN_AT:
                                n_st = f_arm(n_st, w_b[7:4], w_b, 2'd1);
                            default: begin
                            end
                        endcase
                    end
                endcase
            end else if (r_st.running_status == ST_SYSEX) begin
                if (r_st.collected_count >= COUNT_W'(SYSEX_MAX)) begin
                    n_st = f_clear(n_st);
                end else begin
                    w_res.sysex_write    = 1'b1;
                    w_res.sysex_index    = r_st.collected_count;
                    w_res.sysex_data     = w_b[6:0];
                    n_st.collected_count = w_cnt_inc;
                end
            end else if (r_st.expected_bytes != 2'd0) begin
                if (w_cnt_inc == {{(COUNT_W-2){1'b0}}, r_st.expected_bytes}) begin
                    // note-on with zero velocity goes out as note-off
                    if (r_st.running_status[7:4] == NIB_NOTE_ON && w_b == 8'd0) begin
                        w_cin = CIN_NOTE_OFF;
                        w_sb  = r_st.running_status & ~NOTE_ON_OFF_BIT;
                    end
                    if (r_st.expected_bytes == 2'd2) begin
                        w_res = f_emit(r_cable, w_cin, w_sb, {1'b0, r_st.first_data}, w_b,
                                       i_word.arrival_time);
                    end else begin
                        w_res = f_emit(r_cable, w_cin, w_sb, w_b, 8'd0, i_word.arrival_time);
                    end
                    if (r_st.code_index == CIN_SYS3 || r_st.code_index == CIN_SYS2) begin
                        n_st = f_clear(n_st);
                    end else begin
                        n_st.collected_count = '0;
                    end
                end else begin
                    n_st.first_data      = w_b[6:0];
                    n_st.collected_count = w_cnt_inc;
                end
            end
        end
        if (i_word.overrun) begin
            n_st = f_clear(n_st);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_cable <= CABLE_RESET;
        end else begin
            if (i_step) begin
                r_st <= n_st;
            end
            if (i_cfg_we) begin
                r_cable <= i_cfg_data;
            end
        end
    end

    assign o_result = w_res;

endmodule

FILE: rtl/mbup_out_reg.sv
// result register with valid/stall handshake toward the consumer
`timescale 1ns / 1ps

module mbup_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mbup_pkg::t_out_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    output mbup_pkg::t_out_word o_word,
    input  logic                i_stall
);
    import mbup_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: rtl/midi_byte_to_usb_event_parser.sv
// top level of the midi byte to usb-midi event packet parser
`timescale 1ns / 1ps

// Takes one received MIDI byte per word (with its line-error and overrun flags and
// arrival time) and returns exactly one result word per input word: either a 4-byte
// usb-midi event packet (header = cable number and code index), a sysex data byte with
// its buffer index for an external store, or an all-zero word when the byte completes
// nothing. A word flows through an input register, then the decode logic and the parser
// state update, then the result register, which offers it to the consumer, and one word
// is accepted every cycle while the consumer keeps up. The result register frees itself in
// the same cycle its word is taken, so throughput only drops when i_out_stall is held.
// Cable number is written through i_cfg_we / i_cfg_data (reset value 1) and must only
// change while the block is idle.
module midi_byte_to_usb_event_parser #(
    parameter int SYSEX_MAX = mbup_pkg::SYSEX_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_in_valid,
    input  mbup_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mbup_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import mbup_pkg::*;

    // input register stage
    logic      r_in_valid;
    t_in_word  r_in_word;

    logic      w_out_ready;
    logic      w_advance;
    logic      w_accept;
    t_out_word w_result;

    // word moves from the input register into the result register
    assign w_advance  = r_in_valid && w_out_ready;
    // input stage only holds off when it is full and cannot drain
    assign o_in_stall = r_in_valid && !w_out_ready;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // decode and parser state, state commits when the word advances
    mbup_parse #(
        .SYSEX_MAX (SYSEX_MAX)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_advance),
        .i_word     (r_in_word),
        .o_result   (w_result)
    );

    // result register toward the consumer
    mbup_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid),
        .i_word  (w_result),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

    // a packet and a sysex store never come from the same byte
    a_no_event_and_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.event_valid && o_out_word.sysex_write))
        else $error("event packet and sysex store in one word");

    // sysex stores stay inside the buffer
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.sysex_write) |->
            (o_out_word.sysex_index < COUNT_W'(SYSEX_MAX)))
        else $error("sysex index beyond buffer");

    // a word with no packet carries a zero header
    a_idle_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.event_valid) |-> (o_out_word.packet_header == 8'd0))
        else $error("header set without a packet");

    // stall toward the producer only with a word held in the input stage
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a held word");

endmodule

FILE: tb/tb_midi_byte_to_usb_event_parser.sv
// self-checking testbench for the midi byte to usb-midi event packet parser
`timescale 1ns / 1ps

// Drives received midi bytes into the parser through the valid/stall input channel
// and checks every result word against a cycle-free predictor of the parser state.
// A short directed table walks the special cases under the reset cable number, then
// random well-formed messages (running status, sysex from empty to past the buffer
// limit, system common, real-time interleaving) mixed with noise, line errors and
// overruns run under several cable numbers. Both sides insert random gaps, the output
// side holds off for long stretches so the parser backs up, and the input side drains
// before every cable number change.
module tb_midi_byte_to_usb_event_parser;

    import mbup_pkg::*;

    localparam int SYSEX_LIMIT = SYSEX_MAX_DEF;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int PHASE_WORDS = 255;    // least number of random words per cable setting
    localparam int LONG_HOLD   = 300;    // cycles of a long output hold-off

    // one row of the directed table: a word in, and optionally its typed-in result
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_row;

    logic      i_clk;
    logic      rst_n;
    logic      cfg_we;
    logic [3:0] cfg_data;
    logic      in_valid;
    t_in_word  in_word;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall;

    // predictor copy of the parser and its cable number
    t_state     parser_st;
    logic [3:0] cable_reg;

    t_out_word  pending_packets[$];
    t_row       directed_rows[$];
    logic [31:0] tick;
    bit         send_quiet;

    int err_count;
    int n_items;
    int n_results;
    int n_packets;
    int n_sysex;
    int n_lerr;
    int n_ovr;
    logic [3:0] cable_mid_a;
    logic [3:0] cable_mid_b;

    midi_byte_to_usb_event_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // parser reset: first data byte and last time survive
    function automatic void clear_parser();
        parser_st.running_status  = '0;
        parser_st.code_index      = '0;
        parser_st.expected_bytes  = '0;
        parser_st.collected_count = '0;
    endfunction

    // start collecting a new message
    function automatic void arm_parser(logic [3:0] cin, logic [7:0] status, logic [1:0] need);
        parser_st.code_index      = cin;
        parser_st.running_status  = status;
        parser_st.expected_bytes  = need;
        parser_st.collected_count = '0;
    endfunction

    function automatic t_out_word make_packet(logic [3:0] cin, logic [7:0] b0,
                                              logic [7:0] b1, logic [7:0] b2);
        t_out_word r;
        r               = '0;
        r.event_valid   = 1'b1;
        r.packet_header = {cable_reg, cin};
        r.midi_byte0    = b0;
        r.midi_byte1    = b1;
        r.midi_byte2    = b2;
        r.event_time    = parser_st.last_time;
        return r;
    endfunction

    // expected result word for one accepted byte; updates the parser copy
    function automatic t_out_word parse_byte(t_in_word w);
        t_out_word  r;
        logic [7:0] b;
        logic [7:0] sb;
        logic [3:0] cin;
        r = '0;
        b = w.rx_byte;
        if (w.line_error) begin
            // byte thrown away, time not updated
            clear_parser();
        end else begin
            parser_st.last_time = w.arrival_time;
            if (b[7]) begin
                case (b)
                    ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP: begin
                        r = make_packet(CIN_RT, b, 8'h00, 8'h00);
                    end
                    ST_RESET: begin
                        r = make_packet(CIN_RT, b, 8'h00, 8'h00);
                        clear_parser();
                    end
                    ST_ACT_SENSE, ST_UNDEF_F9, ST_UNDEF_FD: begin
                        // ignored, running status kept
                    end
                    ST_SYSEX:    arm_parser(CIN_SYSEX, ST_SYSEX, 2'd2);
                    ST_SONG_POS: arm_parser(CIN_SYS3, b, 2'd2);
                    ST_MTC, ST_SONG_SEL: arm_parser(CIN_SYS2, b, 2'd1);
                    ST_UNDEF_F4, ST_UNDEF_F5: clear_parser();
                    ST_TUNE: begin
                        r = make_packet(CIN_SYS1, b, 8'h00, 8'h00);
                        clear_parser();
                    end
                    ST_EOX: begin
                        // length packet only when sysex bytes were actually stored
                        if (parser_st.running_status == ST_SYSEX &&
                            parser_st.collected_count != 0) begin
                            r = make_packet(CIN_SYSEX, ST_SYSEX,
                                            {2'b00, parser_st.collected_count}, ST_EOX);
                        end
                        clear_parser();
                    end
                    default: begin
                        case (b[7:4])
                            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND:
                                arm_parser(b[7:4], b, 2'd2);
                            NIB_PROG, NIB_CHAN_AT:
                                arm_parser(b[7:4], b, 2'd1);
                            default: begin
                            end
                        endcase
                    end
                endcase
            end else if (parser_st.running_status == ST_SYSEX) begin
                if (parser_st.collected_count >= COUNT_W'(SYSEX_LIMIT)) begin
                    // overflow drops the whole message
                    clear_parser();
                end else begin
                    r.sysex_write = 1'b1;
                    r.sysex_index = parser_st.collected_count;
                    r.sysex_data  = b[6:0];
                    parser_st.collected_count = parser_st.collected_count + COUNT_W'(1);
                end
            end else if (parser_st.expected_bytes != 0) begin
                parser_st.collected_count = parser_st.collected_count + COUNT_W'(1);
                if (parser_st.collected_count == {4'd0, parser_st.expected_bytes}) begin
                    sb  = parser_st.running_status;
                    cin = parser_st.code_index;
                    // note-on with zero velocity goes out as note-off
                    if (sb[7:4] == NIB_NOTE_ON && b == 8'h00) begin
                        cin = CIN_NOTE_OFF;
                        sb  = sb & ~NOTE_ON_OFF_BIT;
                    end
                    if (parser_st.expected_bytes == 2'd2)
                        r = make_packet(cin, sb, {1'b0, parser_st.first_data}, b);
                    else
                        r = make_packet(cin, sb, b, 8'h00);
                    // system common has no running status
                    if (parser_st.code_index == CIN_SYS3 || parser_st.code_index == CIN_SYS2)
                        clear_parser();
                    else
                        parser_st.collected_count = '0;
                end else begin
                    parser_st.first_data = b[6:0];
                end
            end
        end
        if (w.overrun)
            clear_parser();
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_error(string msg);
        err_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d field %s: got %0h, expected %0h",
                                 n_results, name, got, want));
    endtask

    task automatic compare_word(t_out_word got, t_out_word want);
        check_field("event_valid",   32'(got.event_valid),   32'(want.event_valid));
        check_field("packet_header", 32'(got.packet_header), 32'(want.packet_header));
        check_field("midi_byte0",    32'(got.midi_byte0),    32'(want.midi_byte0));
        check_field("midi_byte1",    32'(got.midi_byte1),    32'(want.midi_byte1));
        check_field("midi_byte2",    32'(got.midi_byte2),    32'(want.midi_byte2));
        check_field("event_time",    got.event_time,         want.event_time);
        check_field("sysex_write",   32'(got.sysex_write),   32'(want.sysex_write));
        check_field("sysex_index",   32'(got.sysex_index),   32'(want.sysex_index));
        check_field("sysex_data",    32'(got.sysex_data),    32'(want.sysex_data));
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // output side: take words, compare with the oldest expectation, stall at random
    initial begin : result_side
        int        stall_left;
        int        cycles;
        bit        quiet;
        t_out_word want;
        out_stall  = 1'b0;
        stall_left = 0;
        cycles     = 0;
        quiet      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_packets.size() == 0) begin
                    flag_error($sformatf("result word %0d arrived with nothing expected",
                                         n_results));
                end else begin
                    want = pending_packets.pop_front();
                    compare_word(out_word, want);
                end
                n_results++;
                // long hold-offs so the parser backs up while words keep coming
                if (n_results == 300 || n_results == 700)
                    stall_left = LONG_HOLD;
            end
            cycles++;
            if (cycles % 128 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (stall_left == 0)
                stall_left = quiet ? 0 : pick_gap();
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles where no word moves on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // offer one word after a random gap, wait for it to be taken, record the result
    task automatic drive_word(t_in_word w, bit typed, t_out_word want);
        int        gap;
        t_out_word predicted;
        if (n_items % 64 == 0)
            send_quiet = ($urandom_range(0, 2) == 0);
        gap = send_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        predicted = parse_byte(w);
        if (typed)
            predicted = want;
        pending_packets.push_back(predicted);
        n_items++;
        if (predicted.event_valid)
            n_packets++;
        if (predicted.sysex_write)
            n_sysex++;
        if (w.line_error)
            n_lerr++;
        if (w.overrun)
            n_ovr++;
    endtask

    task automatic add_row(logic [7:0] b, bit lerr, bit ovr, logic [31:0] t,
                           bit typed, t_out_word want);
        t_row row;
        row.w.rx_byte      = b;
        row.w.line_error   = lerr;
        row.w.overrun      = ovr;
        row.w.arrival_time = t;
        row.typed          = typed;
        row.want           = want;
        directed_rows.push_back(row);
    endtask

    // single-byte packet under the reset cable number
    function automatic t_out_word one_byte_packet(logic [3:0] cin, logic [7:0] b0,
                                                  logic [31:0] t);
        t_out_word r;
        r               = '0;
        r.event_valid   = 1'b1;
        r.packet_header = {CABLE_RESET, cin};
        r.midi_byte0    = b0;
        r.event_time    = t;
        return r;
    endfunction

    // one byte with rare random line errors and overruns; time mostly creeps forward
    task automatic send_byte(logic [7:0] b);
        t_in_word w;
        w.rx_byte    = b;
        w.line_error = ($urandom_range(0, 59) == 0);
        w.overrun    = ($urandom_range(0, 59) == 0);
        tick = tick + 32'($urandom_range(0, 2000));
        if ($urandom_range(0, 15) == 0)
            tick = $urandom();
        w.arrival_time = tick;
        drive_word(w, 1'b0, '0);
    endtask

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'h7F;
        return 8'($urandom_range(0, 127));
    endfunction

    // occasional real-time byte dropped into the middle of a message
    task automatic maybe_realtime();
        logic [7:0] rt;
        if ($urandom_range(0, 9) == 0) begin
            rt = 8'($urandom_range(8'hF8, 8'hFF));
            send_byte(rt);
        end
    endtask

    // one random message, mostly well formed
    task automatic play_message();
        int         kind;
        int         need;
        int         len;
        int         r;
        logic [3:0] nib;
        logic [7:0] st;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // channel message followed by running-status repeats
            nib  = 4'($urandom_range(8, 14));
            st   = {nib, 4'($urandom_range(0, 15))};
            need = (nib == NIB_PROG || nib == NIB_CHAN_AT) ? 1 : 2;
            send_byte(st);
            repeat ($urandom_range(1, 4) * need) begin
                maybe_realtime();
                send_byte(rand_data());
            end
            // sometimes a truncated repeat
            if ($urandom_range(0, 7) == 0)
                send_byte(rand_data());
        end else if (kind < 58) begin
            // sysex, a few long enough to reach the buffer limit or overflow
            send_byte(ST_SYSEX);
            r = $urandom_range(0, 19);
            if (r == 0)
                len = $urandom_range(SYSEX_LIMIT - 2, SYSEX_LIMIT + 4);
            else if (r == 1)
                len = 0;
            else
                len = $urandom_range(1, 8);
            repeat (len) begin
                maybe_realtime();
                send_byte(rand_data());
            end
            r = $urandom_range(0, 9);
            if (r < 8) begin
                send_byte(ST_EOX);
            end else if (r == 8) begin
                nib = 4'($urandom_range(8, 14));
                send_byte({nib, 4'h0});
            end
        end else if (kind < 70) begin
            // system common
            case ($urandom_range(0, 5))
                0: begin
                    send_byte(ST_MTC);
                    send_byte(rand_data());
                end
                1: begin
                    send_byte(ST_SONG_SEL);
                    send_byte(rand_data());
                end
                2: begin
                    send_byte(ST_SONG_POS);
                    send_byte(rand_data());
                    send_byte(rand_data());
                end
                3: send_byte(ST_TUNE);
                4: send_byte($urandom_range(0, 1) ? ST_UNDEF_F4 : ST_UNDEF_F5);
                default: send_byte(ST_EOX);
            endcase
            // a stray data byte after system common must be ignored
            if ($urandom_range(0, 2) == 0)
                send_byte(rand_data());
        end else if (kind < 80) begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_packets.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cable(logic [3:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cable_reg  = value;
    endtask

    initial begin : stimulus
        int         target;
        logic [3:0] cable_plan [4];
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = CABLE_RESET;
        in_valid   = 1'b0;
        in_word    = '0;
        parser_st  = '0;
        cable_reg  = CABLE_RESET;
        tick       = '0;
        send_quiet = 1'b0;
        err_count  = 0;
        n_items    = 0;
        n_results  = 0;
        n_packets  = 0;
        n_sysex    = 0;
        n_lerr     = 0;
        n_ovr      = 0;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, run under the reset cable number
        add_row(8'h00, 0, 0, 32'h0000_0000, 1, '0);            // data with no status
        add_row(ST_CLOCK, 0, 0, 32'hFFFF_FFFF, 1,
                one_byte_packet(CIN_RT, ST_CLOCK, 32'hFFFF_FFFF));
        add_row({NIB_NOTE_ON, 4'h0}, 0, 0, 32'd10, 1, '0);
        add_row(8'h3C, 0, 0, 32'd11, 0, '0);
        add_row(8'h00, 0, 0, 32'd12, 0, '0);                   // zero velocity
        add_row(8'h7F, 0, 0, 32'd13, 0, '0);                   // running status
        add_row(ST_UNDEF_F9, 0, 0, 32'd14, 1, '0);
        add_row(8'h7F, 0, 0, 32'd15, 0, '0);
        add_row({NIB_PROG, 4'hF}, 0, 0, 32'd16, 1, '0);
        add_row(8'h7F, 0, 0, 32'd17, 0, '0);
        add_row(ST_SYSEX, 0, 0, 32'd18, 1, '0);
        add_row(8'h00, 0, 0, 32'd19, 0, '0);
        add_row(ST_ACT_SENSE, 0, 0, 32'd20, 1, '0);            // ignored inside sysex
        add_row(8'h7F, 0, 0, 32'd21, 0, '0);
        add_row(ST_EOX, 0, 0, 32'd22, 0, '0);                  // length packet
        add_row(ST_EOX, 0, 0, 32'd23, 1, '0);                  // eox outside sysex
        add_row(ST_SONG_POS, 0, 0, 32'd24, 1, '0);
        add_row(8'h01, 0, 0, 32'd25, 0, '0);
        add_row(8'h02, 0, 0, 32'd26, 0, '0);
        add_row(8'h03, 0, 0, 32'd27, 1, '0);                   // no running status
        add_row(ST_TUNE, 0, 0, 32'd28, 1, one_byte_packet(CIN_SYS1, ST_TUNE, 32'd28));
        add_row({NIB_BEND, 4'h3}, 0, 0, 32'd29, 1, '0);
        add_row(ST_UNDEF_F4, 0, 0, 32'd30, 1, '0);             // clears the parser
        add_row(8'h20, 0, 0, 32'd31, 1, '0);
        add_row(ST_RESET, 0, 0, 32'd32, 1, one_byte_packet(CIN_RT, ST_RESET, 32'd32));
        add_row({NIB_CTRL, 4'h0}, 0, 0, 32'd33, 1, '0);
        add_row(8'h64, 1, 0, 32'd34, 1, '0);                   // line error
        add_row(8'h64, 0, 0, 32'd35, 1, '0);
        add_row({NIB_CHAN_AT, 4'h1}, 0, 1, 32'd36, 1, '0);     // overrun clears after
        add_row(8'h40, 0, 0, 32'd37, 1, '0);
        foreach (directed_rows[i])
            drive_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own cable number
        cable_mid_a   = 4'($urandom_range(2, 14));
        cable_mid_b   = 4'($urandom_range(0, 15));
        cable_plan[0] = 4'd0;
        cable_plan[1] = 4'd15;
        cable_plan[2] = cable_mid_a;
        cable_plan[3] = cable_mid_b;
        for (int p = 0; p < 4; p++) begin
            drain();
            write_cable(cable_plan[p]);
            target = n_items + PHASE_WORDS;
            while (n_items < target)
                play_message();
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (pending_packets.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", pending_packets.size()));

        $display("%0d bytes driven (%0d line errors, %0d overruns):",
                 n_items, n_lerr, n_ovr);
        $display("  %0d usb-midi packets, %0d sysex stores", n_packets, n_sysex);
        $display("cable numbers 1, 0, 15, %0d, %0d; two long output hold-offs; %0d errors",
                 cable_mid_a, cable_mid_b, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
